// ===== hdl/qpc_pkg.sv =====
// Shared types, constants and a modular-add helper for the queen path counter.
`default_nettype none
package qpc_pkg;

    localparam int COUNT_W = 30;
    localparam int GRID_W_W = 11;

    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [GRID_W_W-1:0] grid_width_t;

    localparam logic [31:0] PRIME_MOD   = 32'd1000000007;
    localparam logic [31:0] PRIME_MOD_2 = 32'd2000000014;
    localparam grid_width_t GRID_WIDTH_RESET = 11'd1024;

    typedef struct packed {
        count_t horiz;
        count_t vert;
        count_t diag;
    } sums_t;

    // Sum of three residues, each below the prime, reduced back below the prime.
    function automatic count_t add_mod3(count_t a, count_t b, count_t c);
        logic [31:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        if (s >= PRIME_MOD_2)
        begin
            s = s - PRIME_MOD_2;
        end
        else if (s >= PRIME_MOD)
        begin
            s = s - PRIME_MOD;
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/qpc_ifs.sv =====
// Valid/ready channel interfaces for grid cells in and path counts out.
`default_nettype none
interface qpc_cell_if;
    logic valid;
    logic ready;
    logic blocked;
    logic grid_start;

    modport source (output valid, output blocked, output grid_start, input ready);
    modport sink (input valid, input blocked, input grid_start, output ready);
endinterface

interface qpc_count_if;
    logic        valid;
    logic        ready;
    logic [29:0] path_count;

    modport source (output valid, output path_count, input ready);
    modport sink (input valid, input path_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/qpc_row_mem.sv =====
// Row buffer: one write port, one registered read port.
`default_nettype none
module qpc_row_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 60
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DW-1:0]            rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/qpc_col_ctrl.sv =====
// Column index and first-row tracking for each accepted cell.
`default_nettype none
module qpc_col_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          grid_start,
    input  wire qpc_pkg::grid_width_t          grid_width,
    output logic      [$clog2(MAX_WIDTH)-1:0]  col,
    output logic                               first_row
);
    import qpc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam int EW = (CW > GRID_W_W) ? CW : GRID_W_W;

    logic [AW-1:0] col_reg, col_next;
    logic          first_reg, first_next;
    logic [EW-1:0] gw_ext, max_ext, act_w, c0_ext;
    logic          f0, wrap, last;

    assign gw_ext  = EW'(grid_width);
    assign max_ext = EW'(MAX_WIDTH);
    assign act_w   = (gw_ext == '0) ? EW'(1) : ((gw_ext > max_ext) ? max_ext : gw_ext);

    assign c0_ext = grid_start ? '0 : EW'(col_reg);
    assign f0     = grid_start ? 1'b1 : first_reg;
    assign wrap   = (c0_ext >= act_w);

    assign col       = wrap ? '0 : c0_ext[AW-1:0];
    assign first_row = wrap ? 1'b0 : f0;

    assign last       = ((EW'(col) + EW'(1)) >= act_w);
    assign col_next   = last ? '0 : (col + AW'(1));
    assign first_next = last ? 1'b0 : first_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            first_reg <= first_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/qpc_cell_calc.sv =====
// Per-cell path count and updated running sums, all modulo the prime.
`default_nettype none
module qpc_cell_calc (
    input  wire logic            blocked,
    input  wire logic            top_left,
    input  wire qpc_pkg::count_t left_h,
    input  wire qpc_pkg::count_t up_v,
    input  wire qpc_pkg::count_t up_dg,
    output qpc_pkg::count_t      count,
    output qpc_pkg::sums_t       sums
);
    import qpc_pkg::*;

    count_t sum3;

    assign sum3 = add_mod3(left_h, up_v, up_dg);

    assign count = blocked ? '0 : (top_left ? COUNT_W'(1) : sum3);

    assign sums.horiz = blocked ? '0 : add_mod3(left_h, count, '0);
    assign sums.vert  = blocked ? '0 : add_mod3(up_v, count, '0);
    assign sums.diag  = blocked ? '0 : add_mod3(up_dg, count, '0);
endmodule
`default_nettype wire

// ===== hdl/queen_move_path_count_grid.sv =====
// Top level: streaming queen-move path counter over a row-major grid.
//
// Cells enter on cell_in (blocked, grid_start), one beat per cell in
// row-major order; grid_start marks the top-left cell of a new grid.
// Each cell yields one beat on count_out carrying the number of
// right/down/down-right queen-move paths from the top-left cell, mod
// 1000000007. cfg_we/cfg_wdata set the row width (0 reads as 1, values
// above MAX_WIDTH saturate); write it only while the block is idle.
// Throughput: one cell per cycle while count_out is not stalling. An
// accepted cell is held in the compute stage registers, then its count
// moves into the output register that presents count_out.valid. A cell
// is read from the row buffer on its accepting edge and its column is
// written back as it leaves the compute stage, with a bypass when consecutive cells share a column.
// Reset leaves the width at 1024 and treats the next cell as top-left.
// Row-buffer columns not yet written since reset read as zero (fill count),
// so no clearing pass is needed. When count_out stalls, the output register
// holds, one more cell may sit in the compute stage, then cell_in.ready drops.
`default_nettype none
module queen_move_path_count_grid #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    qpc_cell_if.sink         cell_in,
    qpc_count_if.source      count_out,
    input  wire logic        cfg_we,
    input  wire logic [10:0] cfg_wdata
);
    import qpc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;

    grid_width_t grid_width_reg;

    logic          accept;
    logic [AW-1:0] col;
    logic          first_row;

    logic          s1_valid_reg, s1_blocked_reg, s1_first_reg;
    logic          s1_fresh_reg, s1_fwd_reg;
    logic [AW-1:0] s1_col_reg;
    count_t        fwd_v_reg, fwd_d_reg;
    logic          s1_adv;

    count_t        h_reg, pd_reg;
    logic [CW-1:0] fill_reg;

    logic [2*COUNT_W-1:0] rd_data;
    count_t        rd_v, rd_d, up_v, up_d, left_h, up_dg;
    logic          col_zero;
    count_t        count;
    sums_t         sums;
    logic          fwd_now, fresh_now;

    logic          out_valid_reg;
    count_t        path_count_reg;

    assign s1_adv         = s1_valid_reg && (!out_valid_reg || count_out.ready);
    assign cell_in.ready  = !s1_valid_reg || s1_adv;
    assign accept         = cell_in.valid && cell_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            grid_width_reg <= cfg_wdata;
        end
    end

    qpc_col_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .grid_start (cell_in.grid_start),
        .grid_width (grid_width_reg),
        .col        (col),
        .first_row  (first_row)
    );

    qpc_row_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (2 * COUNT_W)
    ) u_row_mem (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({sums.vert, sums.diag}),
        .re    (accept),
        .raddr (col),
        .rdata (rd_data)
    );

    // Bypass the write landing on the same edge as the read.
    assign fwd_now   = s1_adv && (s1_col_reg == col);
    assign fresh_now = (CW'(col) < fill_reg) || fwd_now;

    assign rd_v     = rd_data[2*COUNT_W-1:COUNT_W];
    assign rd_d     = rd_data[COUNT_W-1:0];
    assign up_v     = (s1_first_reg || !s1_fresh_reg) ? '0 : (s1_fwd_reg ? fwd_v_reg : rd_v);
    assign up_d     = (s1_first_reg || !s1_fresh_reg) ? '0 : (s1_fwd_reg ? fwd_d_reg : rd_d);
    assign col_zero = (s1_col_reg == '0);
    assign left_h   = col_zero ? '0 : h_reg;
    assign up_dg    = (col_zero || s1_first_reg) ? '0 : pd_reg;

    qpc_cell_calc u_cell_calc (
        .blocked  (s1_blocked_reg),
        .top_left (s1_first_reg && col_zero),
        .left_h   (left_h),
        .up_v     (up_v),
        .up_dg    (up_dg),
        .count    (count),
        .sums     (sums)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            h_reg         <= '0;
            pd_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                h_reg         <= sums.horiz;
                pd_reg        <= up_d;
                if (CW'(s1_col_reg) == fill_reg)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            else if (count_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_blocked_reg <= cell_in.blocked;
            s1_first_reg   <= first_row;
            s1_col_reg     <= col;
            s1_fresh_reg   <= fresh_now;
            s1_fwd_reg     <= fwd_now;
            fwd_v_reg      <= sums.vert;
            fwd_d_reg      <= sums.diag;
        end
        if (s1_adv)
        begin
            path_count_reg <= count;
        end
    end

    assign count_out.valid      = out_valid_reg;
    assign count_out.path_count = path_count_reg;

`ifndef SYNTHESIS
    a_blocked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_blocked_reg |=> count_out.valid && (count_out.path_count == '0))
        else $error("blocked cell gave a nonzero count");

    a_count_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        count_out.valid |-> ({2'b00, count_out.path_count} < PRIME_MOD))
        else $error("path count not reduced mod prime");

    a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (CW'(s1_col_reg) <= fill_reg))
        else $error("row buffer column beyond written prefix");
`endif
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for queen_move_path_count_grid: directed cells, then random grids.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qpc_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int ROW_DEPTH   = 1024;
    localparam int MAX_GAP     = 18;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic {STEP_CELL, STEP_WIDTH} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        logic        blocked;
        logic        grid_start;
        bit          given;
        count_t      count;
        grid_width_t width;
    } step_t;

    typedef struct {
        bit     given;
        count_t count;
    } typed_count_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    qpc_cell_if  cell_if();
    qpc_count_if count_if();

    queen_move_path_count_grid u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (cell_if),
        .count_out (count_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // path predictor state
    grid_width_t row_len;
    count_t      down_acc [ROW_DEPTH];
    count_t      diag_acc [ROW_DEPTH];
    count_t      run_acc;
    count_t      diag_carry;
    int unsigned cur_col;
    bit          in_top_row;

    count_t       pending_counts[$];
    typed_count_t typed_counts[$];
    int           cells_sent;
    int           results_seen;
    int           mismatches;
    int           idle_cycles;
    bit           no_idle;

    step_t directed_steps [28] = '{
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd1, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd1, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd2, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd4, 11'd0},
        '{STEP_CELL,  1'b1, 1'b0, 1'b1, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b1, 1'b1, 30'd1, 11'd0},
        '{STEP_CELL,  1'b1, 1'b1, 1'b1, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd0, 11'd0},
        '{STEP_WIDTH, 1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b1, 1'b1, 30'd1, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd1, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b1, 30'd2, 11'd0},
        '{STEP_CELL,  1'b1, 1'b0, 1'b1, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_WIDTH, 1'b0, 1'b0, 1'b0, 30'd0, 11'd2047},
        '{STEP_CELL,  1'b0, 1'b1, 1'b1, 30'd1, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b1, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_WIDTH, 1'b0, 1'b0, 1'b0, 30'd0, 11'd2},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b1, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_CELL,  1'b0, 1'b0, 1'b0, 30'd0, 11'd0},
        '{STEP_WIDTH, 1'b0, 1'b0, 1'b0, 30'd0, 11'd1}
    };

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // zero reads as one, anything above the row buffer saturates
    function automatic int unsigned span_of(input grid_width_t setting);
        if (setting == '0)
        begin
            return 1;
        end
        if (setting > ROW_DEPTH)
        begin
            return ROW_DEPTH;
        end
        return 32'(setting);
    endfunction

    function automatic count_t mod_sum(input count_t a, input count_t b, input count_t c);
        longint unsigned total;
        total = longint'(a) + longint'(b) + longint'(c);
        return count_t'(total % PRIME_MOD);
    endfunction

    function automatic count_t next_path_count(input logic blk, input logic start);
        int unsigned span;
        int unsigned c;
        count_t      from_above;
        count_t      diag_above;
        count_t      from_left;
        count_t      from_corner;
        count_t      paths;
        span = span_of(row_len);
        if (start)
        begin
            cur_col    = 0;
            in_top_row = 1'b1;
            run_acc    = '0;
            diag_carry = '0;
        end
        if (cur_col >= span)
        begin
            cur_col    = 0;
            in_top_row = 1'b0;
        end
        c           = cur_col;
        from_above  = in_top_row ? '0 : down_acc[c];
        diag_above  = in_top_row ? '0 : diag_acc[c];
        from_left   = (c == 0) ? '0 : run_acc;
        from_corner = (c == 0 || in_top_row) ? '0 : diag_carry;
        if (blk)
        begin
            paths = '0;
        end
        else if (in_top_row && c == 0)
        begin
            paths = count_t'(1);
        end
        else
        begin
            paths = mod_sum(from_left, from_above, from_corner);
        end
        diag_carry = diag_above;
        if (blk)
        begin
            run_acc     = '0;
            down_acc[c] = '0;
            diag_acc[c] = '0;
        end
        else
        begin
            run_acc     = mod_sum(from_left, paths, '0);
            down_acc[c] = mod_sum(from_above, paths, '0);
            diag_acc[c] = mod_sum(from_corner, paths, '0);
        end
        if (c + 1 >= span)
        begin
            cur_col    = 0;
            in_top_row = 1'b0;
        end
        else
        begin
            cur_col = c + 1;
        end
        return paths;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        count_t       want;
        typed_count_t hint;
        if (!rst_n)
        begin
            row_len    = GRID_WIDTH_RESET;
            run_acc    = '0;
            diag_carry = '0;
            cur_col    = 0;
            in_top_row = 1'b1;
            for (int i = 0; i < ROW_DEPTH; i++)
            begin
                down_acc[i] = '0;
                diag_acc[i] = '0;
            end
            pending_counts.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                row_len = cfg_wdata;
            end
            if (cell_if.valid && cell_if.ready)
            begin
                hint = '{1'b0, '0};
                if (typed_counts.size() != 0)
                begin
                    hint = typed_counts.pop_front();
                end
                want = next_path_count(cell_if.blocked, cell_if.grid_start);
                if (hint.given)
                begin
                    want = hint.count;
                end
                pending_counts.push_back(want);
            end
            if (count_if.valid && count_if.ready)
            begin
                results_seen++;
                if (pending_counts.size() == 0)
                begin
                    $error("path_count beat with nothing expected: actual %0d",
                           count_if.path_count);
                    mismatches++;
                end
                else
                begin
                    want = pending_counts.pop_front();
                    if (count_if.path_count !== want)
                    begin
                        $error("path_count mismatch: expected %0d, actual %0d",
                               want, count_if.path_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cell_if.valid && cell_if.ready) || (count_if.valid && count_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // count sink with random stalls and one long hold-off
    initial
    begin : count_sink
        int stall;
        int beats;
        beats = 0;
        count_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (beats == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                count_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            count_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!count_if.valid);
            beats++;
        end
    end

    task automatic send_cell(input logic blk, input logic start, input bit given,
                             input count_t count);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        typed_counts.push_back('{given, count});
        if (gap > 0)
        begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.blocked    <= blk;
        cell_if.grid_start <= start;
        do
            @(posedge clk);
        while (!cell_if.ready);
        cells_sent++;
    endtask

    task automatic wait_drained();
        cell_if.valid <= 1'b0;
        while (results_seen < cells_sent)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_width(input grid_width_t setting);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= setting;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input grid_width_t setting, input int budget, input bit burst);
        int unsigned span;
        int          sent;
        int          kind;
        int          rows;
        int          len;
        int          wall_pct;
        logic        blk;
        logic        start;
        set_width(setting);
        no_idle = burst;
        span = span_of(setting);
        sent = 0;
        while (sent < budget)
        begin
            kind = $urandom_range(0, 9);
            rows = $urandom_range(span > 64 ? 2 : 1, 2 + 48 / span);
            len  = rows * span;
            if (span > 64)
            begin
                wall_pct = $urandom_range(0, 2);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0, 1: wall_pct = 0;
                    2: wall_pct = 5;
                    3: wall_pct = 20;
                    default: wall_pct = 50;
                endcase
            end
            if (kind == 0)
            begin
                len = $urandom_range(1, 30);
            end
            else if (kind == 1)
            begin
                len = $urandom_range(1, len);
            end
            for (int i = 0; i < len && sent < budget; i++)
            begin
                if (kind == 0)
                begin
                    blk   = 1'($urandom_range(0, 1));
                    start = ($urandom_range(0, 7) == 0);
                end
                else
                begin
                    blk   = ($urandom_range(0, 99) < wall_pct);
                    start = (i == 0);
                end
                send_cell(blk, start, 1'b0, '0);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        cells_sent   = 0;
        results_seen = 0;
        mismatches   = 0;
        idle_cycles  = 0;
        no_idle      = 1'b0;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        cell_if.valid      <= 1'b0;
        cell_if.blocked    <= 1'b0;
        cell_if.grid_start <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WIDTH)
            begin
                set_width(directed_steps[i].width);
            end
            else
            begin
                send_cell(directed_steps[i].blocked, directed_steps[i].grid_start,
                          directed_steps[i].given, directed_steps[i].count);
            end
        end

        run_phase(grid_width_t'(1), 25, 1'b0);
        run_phase(grid_width_t'(2), 25, 1'b1);
        run_phase(grid_width_t'($urandom_range(1024, 2047)), 1064, 1'b0);
        run_phase(grid_width_t'(3), 25, 1'b0);
        run_phase(grid_width_t'(5), 25, 1'b0);
        run_phase(grid_width_t'(8), 25, 1'b1);
        run_phase(grid_width_t'(13), 25, 1'b0);
        run_phase(grid_width_t'(0), 30, 1'b0);
        run_phase(grid_width_t'($urandom_range(1, 40)), 25, 1'b0);
        run_phase(grid_width_t'($urandom_range(1025, 2047)), 40, 1'b0);
        run_phase(grid_width_t'($urandom_range(4, 24)), 25, 1'b0);
        run_phase(grid_width_t'(1024), 40, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_counts.size() != 0)
        begin
            $error("path_count beats missing: %0d still expected", pending_counts.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/qpc_pkg.sv
hdl/qpc_ifs.sv
hdl/qpc_row_mem.sv
hdl/qpc_col_ctrl.sv
hdl/qpc_cell_calc.sv
hdl/queen_move_path_count_grid.sv
verif/testbench.sv
